FILE: src/sgrb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sgrb_pkg
// Shared types and constants of the scaled glyph rectangle blitter.
// ----------------------------------------------------------------------------
package sgrb_pkg;

  // Glyph store geometry
  localparam int GLYPH_COUNT = 128;
  localparam int GLYPH_ROWS  = 8;
  localparam int STORE_DEPTH = GLYPH_COUNT * GLYPH_ROWS;
  localparam int CODE_W      = (GLYPH_COUNT > 1) ? $clog2(GLYPH_COUNT) : 1;
  localparam int ROW_W       = $clog2(GLYPH_ROWS);
  localparam int STORE_AW    = CODE_W + ROW_W;

  // Highest character code that is ever drawn
  localparam logic [7:0] MAX_CODE = 8'd127;

  // Item operation codes
  typedef enum logic [1:0] {
    OP_LOAD     = 2'd0,
    OP_DRAW_X   = 2'd1,
    OP_DRAW_CUR = 2'd2,
    OP_RSVD     = 2'd3
  } op_t;

  // Configuration register indexes
  typedef enum logic [1:0] {
    CFG_BASE   = 2'd0,
    CFG_WIDTH  = 2'd1,
    CFG_HEIGHT = 2'd2,
    CFG_PITCH  = 2'd3
  } cfg_idx_t;

  typedef struct packed {
    logic [1:0]  op;
    logic [7:0]  char_code;
    logic [2:0]  row_index;
    logic [7:0]  row_bits;
    logic [15:0] x_pos;
    logic [15:0] y_pos;
    logic [31:0] color;
    logic [7:0]  scale;
  } sgrb_in_t;

  typedef struct packed {
    logic [47:0] fill_address;
    logic [7:0]  fill_width;
    logic [7:0]  fill_height;
    logic [31:0] fill_color;
    logic        last;
  } sgrb_out_t;

endpackage

FILE: src/scaled_glyph_rect_blitter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scaled_glyph_rect_blitter
// Turns 8x8 glyphs, magnified by an integer scale, into clipped fill
// rectangles for a 32-bit framebuffer; the glyph store is loaded row by row.
// ----------------------------------------------------------------------------
//  channel   ports                       handshake
//  --------  --------------------------  ------------------------------------
//  input     start, busy, in_item        taken when start & !busy
//  result    out_valid, out_item         one-cycle strobe, cannot be held off
//  config    cfg_we, cfg_index, cfg_wdata written when cfg_we is high
//
//  After reset the glyph store is zeroed, one row per cycle, over all
//  STORE_DEPTH (1024) entries with busy high. A load or ignored item leaves
//  the block idle. A draw walks the eight glyph rows through the store read
//  port: an empty row is read and checked; a non-empty one is read, checked
//  and multiplied, given its row address, then walked column by column. A
//  flush ends the draw. Rectangles leave at most one per cycle.
// ----------------------------------------------------------------------------
module scaled_glyph_rect_blitter (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  sgrb_pkg::sgrb_in_t in_item,
  output logic              out_valid,
  output sgrb_pkg::sgrb_out_t out_item,
  input  logic              cfg_we,
  input  logic [1:0]        cfg_index,
  input  logic [47:0]       cfg_wdata
);

  import sgrb_pkg::*;

  typedef enum logic [6:0] {
    S_CLEAR   = 7'b0000001,
    S_IDLE    = 7'b0000010,
    S_ROW_RD  = 7'b0000100,
    S_ROW_CHK = 7'b0001000,
    S_ROW_MUL = 7'b0010000,
    S_COL     = 7'b0100000,
    S_FLUSH   = 7'b1000000
  } state_t;

  // Control state
  state_t              state_r, state_nxt;
  logic [STORE_AW-1:0] clr_cnt_r, clr_cnt_nxt;
  logic [15:0]         cursor_r, cursor_nxt;
  logic [47:0]         base_r, base_nxt;
  logic [15:0]         fw_r, fw_nxt;
  logic [15:0]         fh_r, fh_nxt;
  logic [15:0]         pitch_r, pitch_nxt;
  logic [ROW_W-1:0]    row_r, row_nxt;
  logic [2:0]          col_r, col_nxt;
  logic                pend_v_r, pend_v_nxt;
  logic                out_valid_r, out_valid_nxt;

  // Walk payload
  logic [CODE_W-1:0]   code_r, code_nxt;
  logic [16:0]         top_r, top_nxt;
  logic [16:0]         left_r, left_nxt;
  logic [15:0]         x_r, x_nxt;
  logic [7:0]          scale_r, scale_nxt;
  logic [31:0]         color_r, color_nxt;
  logic [7:0]          bits_r, bits_nxt;
  logic [7:0]          height_r, height_nxt;
  logic [32:0]         prod_r, prod_nxt;
  logic [47:0]         row_addr_r, row_addr_nxt;
  sgrb_out_t           pend_r, pend_nxt;
  sgrb_out_t           out_item_r, out_item_nxt;

  // Store ports
  logic                ram_we;
  logic [STORE_AW-1:0] ram_waddr;
  logic [7:0]          ram_wdata;
  logic [STORE_AW-1:0] ram_raddr;
  logic [7:0]          ram_rdata;

  // Helpers
  logic        accept;
  logic        code_in_store;
  logic        draw_ok;
  logic [15:0] draw_x;
  logic [16:0] cursor_sum;
  logic [16:0] fw_ext;
  logic [16:0] fh_ext;
  logic [16:0] col_room;
  logic [16:0] row_room;
  logic        rect_hit;
  sgrb_out_t   rect;

  sgrb_ram #(
    .WIDTH (8),
    .DEPTH (STORE_DEPTH)
  ) u_glyph_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign accept        = start && (state_r == S_IDLE);
  assign code_in_store = ({1'b0, in_item.char_code} < 9'(GLYPH_COUNT));
  assign draw_ok       = (base_r != 48'd0) && (in_item.char_code <= MAX_CODE) &&
                         code_in_store && (in_item.scale != 8'd0);
  assign draw_x        = (op_t'(in_item.op) == OP_DRAW_X) ? in_item.x_pos : cursor_r;
  assign cursor_sum    = {1'b0, draw_x} + 17'({in_item.scale, 3'b000});

  assign fw_ext   = {1'b0, fw_r};
  assign fh_ext   = {1'b0, fh_r};
  assign col_room = fw_ext - left_r;
  assign row_room = fh_ext - top_r;

  // Candidate rectangle for the current column
  assign rect_hit = (state_r == S_COL) && bits_r[col_r] && (left_r < fw_ext);
  always_comb begin
    rect.fill_address = row_addr_r + 48'({left_r, 2'b00});
    rect.fill_width   = (col_room > 17'(scale_r)) ? scale_r : col_room[7:0];
    rect.fill_height  = height_r;
    rect.fill_color   = color_r;
    rect.last         = 1'b0;
  end

  // Store write port: clearing sweep or glyph row load
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = clr_cnt_r;
    ram_wdata = 8'd0;
    if (state_r == S_CLEAR) begin
      ram_we = 1'b1;
    end else if (accept && (op_t'(in_item.op) == OP_LOAD) && code_in_store) begin
      ram_we    = 1'b1;
      ram_waddr = {in_item.char_code[CODE_W-1:0], in_item.row_index};
      ram_wdata = in_item.row_bits;
    end
  end

  assign ram_raddr = {code_r, row_r};

  // Sequencer
  always_comb begin
    state_nxt     = state_r;
    clr_cnt_nxt   = clr_cnt_r;
    cursor_nxt    = cursor_r;
    base_nxt      = base_r;
    fw_nxt        = fw_r;
    fh_nxt        = fh_r;
    pitch_nxt     = pitch_r;
    row_nxt       = row_r;
    col_nxt       = col_r;
    pend_v_nxt    = pend_v_r;
    out_valid_nxt = 1'b0;
    code_nxt      = code_r;
    top_nxt       = top_r;
    left_nxt      = left_r;
    x_nxt         = x_r;
    scale_nxt     = scale_r;
    color_nxt     = color_r;
    bits_nxt      = bits_r;
    height_nxt    = height_r;
    prod_nxt      = prod_r;
    row_addr_nxt  = row_addr_r;
    pend_nxt      = pend_r;
    out_item_nxt  = out_item_r;

    // Configuration writes
    if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_BASE:   base_nxt  = cfg_wdata;
        CFG_WIDTH:  fw_nxt    = cfg_wdata[15:0];
        CFG_HEIGHT: fh_nxt    = cfg_wdata[15:0];
        CFG_PITCH:  pitch_nxt = cfg_wdata[15:0];
        default: ;
      endcase
    end

    unique case (state_r)
      S_CLEAR: begin
        clr_cnt_nxt = clr_cnt_r + 1'b1;
        if (clr_cnt_r == STORE_AW'(STORE_DEPTH - 1)) begin
          state_nxt = S_IDLE;
        end
      end

      S_IDLE: begin
        if (accept && ((op_t'(in_item.op) == OP_DRAW_X) ||
                       (op_t'(in_item.op) == OP_DRAW_CUR))) begin
          // Advance the cursor even when nothing is drawn
          cursor_nxt = cursor_sum[16] ? 16'hFFFF : cursor_sum[15:0];
          code_nxt   = in_item.char_code[CODE_W-1:0];
          x_nxt      = draw_x;
          top_nxt    = {1'b0, in_item.y_pos};
          scale_nxt  = in_item.scale;
          color_nxt  = in_item.color;
          row_nxt    = '0;
          if (draw_ok) begin
            state_nxt = S_ROW_RD;
          end
        end
      end

      S_ROW_RD: begin
        state_nxt = S_ROW_CHK;
      end

      S_ROW_CHK: begin
        bits_nxt   = ram_rdata;
        height_nxt = (row_room > 17'(scale_r)) ? scale_r : row_room[7:0];
        prod_nxt   = top_r * pitch_r;
        if (ram_rdata == 8'd0) begin
          // Skip an empty row
          row_nxt   = row_r + 1'b1;
          top_nxt   = top_r + 17'(scale_r);
          state_nxt = (row_r == ROW_W'(GLYPH_ROWS - 1)) ? S_FLUSH : S_ROW_RD;
        end else if (top_r >= fh_ext) begin
          // Row starts below the frame: stop the walk
          state_nxt = S_FLUSH;
        end else begin
          state_nxt = S_ROW_MUL;
        end
      end

      S_ROW_MUL: begin
        row_addr_nxt = base_r + 48'({prod_r, 2'b00});
        left_nxt     = {1'b0, x_r};
        col_nxt      = '0;
        state_nxt    = S_COL;
      end

      S_COL: begin
        // Hold one rectangle back so the final one can be marked
        if (rect_hit) begin
          if (pend_v_r) begin
            out_valid_nxt = 1'b1;
            out_item_nxt  = pend_r;
          end
          pend_nxt   = rect;
          pend_v_nxt = 1'b1;
        end
        left_nxt = left_r + 17'(scale_r);
        col_nxt  = col_r + 1'b1;
        if (col_r == 3'd7) begin
          row_nxt   = row_r + 1'b1;
          top_nxt   = top_r + 17'(scale_r);
          state_nxt = (row_r == ROW_W'(GLYPH_ROWS - 1)) ? S_FLUSH : S_ROW_RD;
        end
      end

      S_FLUSH: begin
        if (pend_v_r) begin
          out_valid_nxt     = 1'b1;
          out_item_nxt      = pend_r;
          out_item_nxt.last = 1'b1;
        end
        pend_v_nxt = 1'b0;
        state_nxt  = S_IDLE;
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_cnt_r   <= '0;
      cursor_r    <= '0;
      base_r      <= '0;
      fw_r        <= '0;
      fh_r        <= '0;
      pitch_r     <= '0;
      row_r       <= '0;
      col_r       <= '0;
      pend_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      cursor_r    <= cursor_nxt;
      base_r      <= base_nxt;
      fw_r        <= fw_nxt;
      fh_r        <= fh_nxt;
      pitch_r     <= pitch_nxt;
      row_r       <= row_nxt;
      col_r       <= col_nxt;
      pend_v_r    <= pend_v_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    code_r     <= code_nxt;
    top_r      <= top_nxt;
    left_r     <= left_nxt;
    x_r        <= x_nxt;
    scale_r    <= scale_nxt;
    color_r    <= color_nxt;
    bits_r     <= bits_nxt;
    height_r   <= height_nxt;
    prod_r     <= prod_nxt;
    row_addr_r <= row_addr_nxt;
    pend_r     <= pend_nxt;
    out_item_r <= out_item_nxt;
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

FILE: src/sgrb_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sgrb_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module sgrb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                                      clk,
  input  logic                                      we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                          wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                          rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

FILE: dv/scaled_glyph_rect_blitter_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scaled_glyph_rect_blitter_tb
// Loads glyph rows, reprograms the frame geometry between phases and draws
// characters at fixed and cursor positions. A tracker object predicts every
// clipped fill rectangle and compares each strobed rectangle in order.
// ----------------------------------------------------------------------------
module scaled_glyph_rect_blitter_tb;
  import sgrb_pkg::*;

  // Glyph store shadow, frame geometry and the rectangles still to arrive
  class fill_rect_tracker;
    logic [7:0]  glyph_rows [STORE_DEPTH];
    logic [15:0] cursor;
    logic [47:0] base;
    logic [15:0] frame_w;
    logic [15:0] frame_h;
    logic [15:0] pitch;
    sgrb_out_t   pending_rects [$];
    int          errors;

    function new();
      foreach (glyph_rows[k]) glyph_rows[k] = '0;
      cursor  = '0;
      base    = '0;
      frame_w = '0;
      frame_h = '0;
      pitch   = '0;
      errors  = 0;
    endfunction

    function void write_reg(cfg_idx_t idx, logic [47:0] val);
      case (idx)
        CFG_BASE:   base    = val;
        CFG_WIDTH:  frame_w = val[15:0];
        CFG_HEIGHT: frame_h = val[15:0];
        CFG_PITCH:  pitch   = val[15:0];
        default: ;
      endcase
    endfunction

    // Step the cursor by one character cell, saturating at the top column
    function logic [15:0] advance_cursor(logic [15:0] x, logic [7:0] scale);
      int unsigned n;
      n = x + 8 * scale;
      return (n > 65535) ? 16'hFFFF : n[15:0];
    endfunction

    // Walk the glyph row-major and queue one clipped rectangle per set bit inside the frame
    function void render_glyph(logic [7:0] code, logic [15:0] x, logic [15:0] y,
                               logic [31:0] color, logic [7:0] scale);
      int unsigned top, bottom, left, right;
      logic [7:0]  bits;
      logic [63:0] offs, sum;
      sgrb_out_t   rect, prev;
      bit          have_prev;
      have_prev = 1'b0;
      if (base == '0 || code > MAX_CODE || code >= GLYPH_COUNT || scale == '0) return;
      for (int i = 0; i < GLYPH_ROWS; i++) begin
        bits = glyph_rows[code * GLYPH_ROWS + i];
        if (bits == '0) continue;
        top = y + i * scale;
        if (top >= frame_h) break;
        bottom = top + scale;
        if (bottom > frame_h) bottom = frame_h;
        for (int j = 0; j < 8; j++) begin
          if (!bits[j]) continue;
          left = x + j * scale;
          if (left >= frame_w) continue;
          right = left + scale;
          if (right > frame_w) right = frame_w;
          offs = 64'(top) * 64'(pitch) + 64'(left);
          sum  = 64'(base) + (offs << 2);
          rect.fill_address = sum[47:0];
          rect.fill_width   = 8'(right - left);
          rect.fill_height  = 8'(bottom - top);
          rect.fill_color   = color;
          rect.last         = 1'b0;
          // hold each rectangle back one step so the final one can be marked
          if (have_prev) pending_rects.push_back(prev);
          prev      = rect;
          have_prev = 1'b1;
        end
      end
      if (have_prev) begin
        prev.last = 1'b1;
        pending_rects.push_back(prev);
      end
    endfunction

    function void note_item(sgrb_in_t it);
      case (op_t'(it.op))
        OP_LOAD: begin
          if (it.char_code < GLYPH_COUNT)
            glyph_rows[it.char_code * GLYPH_ROWS + it.row_index] = it.row_bits;
        end
        OP_DRAW_X: begin
          render_glyph(it.char_code, it.x_pos, it.y_pos, it.color, it.scale);
          cursor = advance_cursor(it.x_pos, it.scale);
        end
        OP_DRAW_CUR: begin
          render_glyph(it.char_code, cursor, it.y_pos, it.color, it.scale);
          cursor = advance_cursor(cursor, it.scale);
        end
        default: ;
      endcase
    endfunction

    function void check_rect(sgrb_out_t got);
      sgrb_out_t exp_rect;
      if (pending_rects.size() == 0) begin
        $display("%0t: unexpected rectangle, expected none, actual addr %h w %0d h %0d",
                 $time, got.fill_address, got.fill_width, got.fill_height);
        errors++;
        return;
      end
      exp_rect = pending_rects.pop_front();
      if (got.fill_address !== exp_rect.fill_address) begin
        $display("%0t: fill_address expected %h, actual %h",
                 $time, exp_rect.fill_address, got.fill_address);
        errors++;
      end
      if (got.fill_width !== exp_rect.fill_width) begin
        $display("%0t: fill_width expected %0d, actual %0d",
                 $time, exp_rect.fill_width, got.fill_width);
        errors++;
      end
      if (got.fill_height !== exp_rect.fill_height) begin
        $display("%0t: fill_height expected %0d, actual %0d",
                 $time, exp_rect.fill_height, got.fill_height);
        errors++;
      end
      if (got.fill_color !== exp_rect.fill_color) begin
        $display("%0t: fill_color expected %h, actual %h",
                 $time, exp_rect.fill_color, got.fill_color);
        errors++;
      end
      if (got.last !== exp_rect.last) begin
        $display("%0t: last expected %b, actual %b", $time, exp_rect.last, got.last);
        errors++;
      end
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  sgrb_in_t    in_item;
  logic        out_valid;
  sgrb_out_t   out_item;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [47:0] cfg_wdata;

  fill_rect_tracker rects;
  int               idle_pct;

  scaled_glyph_rect_blitter DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_item  (out_item),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard stop in case the block hangs
  initial begin
    #5_000_000;
    $display("TB_ERROR");
    $finish;
  end

  // Watch all three channels on the same edge the block uses
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid) rects.check_rect(out_item);
      if (start && !busy) rects.note_item(in_item);
      if (cfg_we) rects.write_reg(cfg_idx_t'(cfg_index), cfg_wdata);
    end
  end

  // Offer one item, idling first at random, and hold it until accepted
  task automatic send_item(input sgrb_in_t it);
    while ($urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start   <= 1'b1;
    in_item <= it;
    do @(posedge clk); while (busy);
  endtask

  // Drop start and wait until every rectangle is in and the block is quiet
  task automatic settle();
    start <= 1'b0;
    @(posedge clk);
    while (rects.pending_rects.size() != 0) @(posedge clk);
    while (busy) @(posedge clk);
    repeat (100) @(posedge clk);
  endtask

  task automatic put_reg(input cfg_idx_t idx, input logic [47:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
  endtask

  task automatic set_frame(input logic [47:0] base, input logic [15:0] w,
                           input logic [15:0] h, input logic [15:0] pitch);
    put_reg(CFG_BASE, base);
    put_reg(CFG_WIDTH, 48'(w));
    put_reg(CFG_HEIGHT, 48'(h));
    put_reg(CFG_PITCH, 48'(pitch));
    cfg_we <= 1'b0;
  endtask

  function automatic sgrb_in_t glyph_load(logic [7:0] code, logic [2:0] row,
                                          logic [7:0] bits);
    sgrb_in_t it;
    it           = '0;
    it.op        = OP_LOAD;
    it.char_code = code;
    it.row_index = row;
    it.row_bits  = bits;
    return it;
  endfunction

  function automatic sgrb_in_t glyph_draw(op_t op, logic [7:0] code, logic [15:0] x,
                                          logic [15:0] y, logic [31:0] color,
                                          logic [7:0] scale);
    sgrb_in_t it;
    it           = '0;
    it.op        = op;
    it.char_code = code;
    it.x_pos     = x;
    it.y_pos     = y;
    it.color     = color;
    it.scale     = scale;
    return it;
  endfunction

  // Mostly loads and draws over a small pool of glyphs, some noise
  function automatic sgrb_in_t make_item();
    logic [95:0] noise;
    sgrb_in_t    it;
    int          pick;
    noise = {$urandom, $urandom, $urandom};
    it    = noise[$bits(sgrb_in_t)-1:0];
    pick  = $urandom_range(0, 99);
    it.char_code = ($urandom_range(0, 9) == 0) ? 8'($urandom) : 8'($urandom_range(0, 15));
    if (pick < 30) begin
      it.op = OP_LOAD;
      case ($urandom_range(0, 3))
        0: it.row_bits = 8'hFF;
        1: it.row_bits = 8'h00;
        default: ;
      endcase
    end else if (pick < 88) begin
      it.op    = ($urandom_range(0, 1) != 0) ? OP_DRAW_X : OP_DRAW_CUR;
      it.scale = ($urandom_range(0, 7) == 0) ? 8'($urandom) : 8'($urandom_range(1, 6));
      // keep most cells near the visible frame so clipping gets exercised
      if ($urandom_range(0, 7) != 0) begin
        it.x_pos = 16'($urandom_range(0, rects.frame_w));
        it.y_pos = 16'($urandom_range(0, rects.frame_h));
      end
    end else if (pick < 94) begin
      it.op = OP_RSVD;
    end else begin
      it.op    = OP_DRAW_X;
      it.scale = '0;
    end
    return it;
  endfunction

  initial begin
    logic [47:0] base;
    logic [15:0] w, h, pitch;
    rects     = new();
    rst_n     = 1'b0;
    start     = 1'b0;
    in_item   = '0;
    cfg_we    = 1'b0;
    cfg_index = CFG_BASE;
    cfg_wdata = '0;
    idle_pct  = 32;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // Draw with the base still zero: nothing comes out, cursor still moves
    send_item(glyph_draw(OP_DRAW_X, 8'd65, 16'd100, 16'd20, 32'h00FF00FF, 8'd3));
    settle();
    set_frame(48'h0000_1000_0000, 16'd640, 16'd480, 16'd640);

    // Load a sparse glyph, a full glyph and an out-of-store code
    send_item(glyph_load(8'd65, 3'd0, 8'hFF));
    send_item(glyph_load(8'd65, 3'd3, 8'h81));
    send_item(glyph_load(8'd65, 3'd7, 8'h18));
    for (int r = 0; r < GLYPH_ROWS; r++) send_item(glyph_load(8'd127, 3'(r), 8'hFF));
    send_item(glyph_load(8'd200, 3'd0, 8'hFF));

    // Full glyph, wide clip, edge clip, zero scale, cursor, out-of-store, empty glyph and reserved items
    send_item(glyph_draw(OP_DRAW_X, 8'd127, 16'd0, 16'd0, 32'hFFFFFFFF, 8'd1));
    send_item(glyph_draw(OP_DRAW_X, 8'd65, 16'd0, 16'd0, 32'h00000001, 8'd255));
    send_item(glyph_draw(OP_DRAW_X, 8'd65, 16'd636, 16'd476, 32'h12345678, 8'd4));
    send_item(glyph_draw(OP_DRAW_X, 8'd65, 16'd10, 16'd10, 32'hDEADBEEF, 8'd0));
    send_item(glyph_draw(OP_DRAW_CUR, 8'd65, 16'd0, 16'd50, 32'hCAFEF00D, 8'd2));
    send_item(glyph_draw(OP_DRAW_CUR, 8'd127, 16'd0, 16'd100, 32'h80000000, 8'd1));
    send_item(glyph_draw(OP_DRAW_X, 8'd200, 16'd20, 16'd20, 32'h0000FFFF, 8'd1));
    send_item(glyph_draw(OP_DRAW_X, 8'd0, 16'd30, 16'd30, 32'hFFFF0000, 8'd2));
    send_item(glyph_draw(OP_RSVD, 8'd65, 16'd40, 16'd40, 32'h55555555, 8'd1));
    send_item(glyph_draw(OP_DRAW_X, 8'd65, 16'hFFFF, 16'hFFFF, 32'hAAAAAAAA, 8'd255));
    send_item(glyph_draw(OP_DRAW_CUR, 8'd65, 16'd0, 16'd0, 32'h01010101, 8'd1));

    // Random phases over extreme and ordinary frame settings
    for (int p = 0; p < 10; p++) begin
      settle();
      case (p)
        0: begin base = 48'hFFFF_FFFF_FFFF; w = 16'hFFFF; h = 16'hFFFF; pitch = 16'hFFFF; end
        1: begin base = 48'd1; w = 16'd0; h = 16'd300; pitch = 16'($urandom); end
        2: begin base = 48'({$urandom, $urandom}); w = 16'd300; h = 16'd0; pitch = 16'd300; end
        3: begin base = 48'd0; w = 16'd640; h = 16'd480; pitch = 16'd640; end
        4: begin base = 48'({$urandom, $urandom}); w = 16'd200; h = 16'd150; pitch = 16'd0; end
        default: begin
          base  = 48'({$urandom, $urandom});
          w     = 16'($urandom_range(1, 1024));
          h     = 16'($urandom_range(1, 768));
          pitch = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(w, 2048));
        end
      endcase
      set_frame(base, w, h, pitch);
      idle_pct = (p < 4) ? 32 : (p < 7) ? 75 : 0;
      for (int k = 0; k < 33; k++) send_item(make_item());
    end

    settle();
    if (rects.errors == 0 && rects.pending_rects.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
